>>> rtl/mabr_pkg.sv
// Shared constants, register map and sequencer state type for the
// moving-average background removal core. No dependencies.
`default_nettype none

package mabr_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int WINDOW_DEPTH_DEF      = 128;
  localparam int MAX_TRACE_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF       = 16;

  // Result index field saturates at its full width
  localparam int                  INDEX_BITS = 12;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

  // Configuration register map
  localparam int              WINDOW_SIZE_BITS  = 7;
  localparam logic [WINDOW_SIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd15;
  localparam int              CFG_ADDR_BITS     = 3;
  localparam int              CFG_DATA_BITS     = 32;
  localparam logic            REG_IDX_WINDOW_SIZE = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_OLD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/mabr_if.sv
// Valid/ready channel interfaces for the sample input and residual output.
// Depends on mabr_pkg for default widths.
`default_nettype none

interface mabr_in_if #(
  parameter int SAMPLE_BITS = mabr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface mabr_out_if #(
  parameter int SAMPLE_BITS = mabr_pkg::SAMPLE_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [SAMPLE_BITS:0]           residual;
  logic [mabr_pkg::INDEX_BITS-1:0]       sample_index;
  logic                                  last_result;

  modport source (output valid, residual, sample_index, last_result, input ready);
  modport sink   (input valid, residual, sample_index, last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/moving_average_background_removal_core.sv
// Centered moving-average background removal over one radar trace.
// Depends on mabr_pkg, mabr_in_if / mabr_out_if and mabr_div.
`default_nettype none

// Streams the samples of one trace and returns, for every index t, the sample
// minus the truncated mean of the samples t-h .. t+h, windows clipped at both
// trace ends, with h = window_size/2 after an odd round-up, capped at
// (WINDOW_DEPTH-1)/2 and latched at the first sample of each trace. Results lag
// the input by h samples; the flagged last sample (or the sample at index
// MAX_TRACE_SAMPLES-1) flushes all remaining results one after another. A
// sample that produces no result is only accepted. A sample that produces a
// result goes through the accept, two sample-memory reads, a divider run over
// every bit of the window sum magnitude, and the output write. Each further
// result of a flush skips the accept, and a stalled output holds the output
// write. The input stalls during this time; a finished result sits in the
// output register while the next sample is taken. The sample memory is not
// cleared after reset: only entries written in the current trace are read.
module moving_average_background_removal_core #(
  parameter int WINDOW_DEPTH      = mabr_pkg::WINDOW_DEPTH_DEF,
  parameter int MAX_TRACE_SAMPLES = mabr_pkg::MAX_TRACE_SAMPLES_DEF,
  parameter int SAMPLE_BITS       = mabr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  mabr_in_if.sink                                  in_if,
  mabr_out_if.source                               out_if,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mabr_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [mabr_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mabr_pkg::CFG_DATA_BITS-1:0]       prdata,
  output logic                                     pready
);

  localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
  localparam int IDX_W    = $clog2(MAX_TRACE_SAMPLES);
  localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int WIDE_W   = IDX_W + ADDR_W + 1;
  localparam int HALF_CAP = (WINDOW_DEPTH - 1) / 2;
  localparam int WS_W     = mabr_pkg::WINDOW_SIZE_BITS;

  // ---------------------------------------------------------------- registers
  mabr_pkg::state_t state_r, state_nxt;

  logic [WS_W-1:0]              window_size_r;
  logic [ADDR_W-1:0]            half_r;
  logic [IDX_W-1:0]             rcv_r;
  logic [IDX_W-1:0]             newest_r;
  logic [IDX_W-1:0]             out_idx_r;
  logic [ADDR_W-1:0]            wr_ptr_r;
  logic [ADDR_W-1:0]            out_ptr_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic                         fin_r;
  logic                         emit_pend_r;
  logic [CNT_W-1:0]             count_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic                         sum_neg_r;

  logic                                  out_valid_r;
  logic signed [SAMPLE_BITS:0]           residual_r;
  logic [mabr_pkg::INDEX_BITS-1:0]       index_r;
  logic                                  last_r;

  // Sample memory
  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;

  // ------------------------------------------------------------ config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= mabr_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_wr && paddr[2] == mabr_pkg::REG_IDX_WINDOW_SIZE) begin
      window_size_r <= pwdata[WS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mabr_pkg::REG_IDX_WINDOW_SIZE) begin
      prdata = mabr_pkg::CFG_DATA_BITS'(window_size_r);
    end
  end

  // ------------------------------------------------------- derived values
  logic                in_fire;
  logic                out_free;
  logic                emit_fire;
  logic                in_fin;
  logic [ADDR_W-1:0]   half_cfg;
  logic [ADDR_W-1:0]   half_use;
  logic                need_emit;
  logic [WIDE_W-1:0]   lo_w;
  logic [WIDE_W-1:0]   count_w;
  logic                past_half;
  logic [ADDR_W:0]     old_wrap;
  logic [ADDR_W-1:0]   old_addr;
  logic [ADDR_W-1:0]   wr_ptr_inc;
  logic [ADDR_W-1:0]   out_ptr_inc;
  logic                is_last_out;
  logic                div_start;
  logic                div_busy;
  logic [SUM_W-1:0]    div_quo;
  logic [SUM_W-1:0]    sum_mag;
  logic [SAMPLE_BITS:0] mean_mag;
  logic signed [SAMPLE_BITS:0]   mean;
  logic signed [SAMPLE_BITS+1:0] residual_w;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign emit_fire = (state_r == mabr_pkg::ST_EMIT) && out_free;

  // Effective half window: odd round-up, then cap to what the memory holds
  assign half_cfg = (32'(window_size_r[WS_W-1:1]) > HALF_CAP) ?
                    ADDR_W'(HALF_CAP) : ADDR_W'(window_size_r[WS_W-1:1]);
  assign half_use = (rcv_r == '0) ? half_cfg : half_r;

  // Overlong trace ends at the last index whatever the flag
  assign in_fin    = in_if.last_sample || (rcv_r == IDX_W'(MAX_TRACE_SAMPLES - 1));
  assign need_emit = in_fin || (WIDE_W'(rcv_r) >= WIDE_W'(half_use));

  // Window bounds for the current output index
  assign past_half = WIDE_W'(out_idx_r) >= WIDE_W'(half_r);
  assign lo_w      = past_half ? WIDE_W'(out_idx_r) - WIDE_W'(half_r) : '0;
  assign count_w   = WIDE_W'(newest_r) - lo_w + WIDE_W'(1);

  // Memory slot of the sample leaving the window
  assign old_wrap = {1'b0, out_ptr_r} + (ADDR_W+1)'(WINDOW_DEPTH) - {1'b0, half_r};
  assign old_addr = (out_ptr_r >= half_r) ? out_ptr_r - half_r : old_wrap[ADDR_W-1:0];

  assign wr_ptr_inc  = (wr_ptr_r  == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign out_ptr_inc = (out_ptr_r == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : out_ptr_r + 1'b1;
  assign is_last_out = fin_r && (out_idx_r == newest_r);

  // Signed mean from the unsigned quotient, truncated toward zero
  assign sum_mag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign mean_mag   = div_quo[SAMPLE_BITS:0];
  assign mean       = sum_neg_r ? -$signed(mean_mag) : $signed(mean_mag);
  assign residual_w = (SAMPLE_BITS+2)'(cur_r) - (SAMPLE_BITS+2)'(mean);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mabr_pkg::ST_IDLE: begin
        if (in_fire && need_emit) begin
          state_nxt = mabr_pkg::ST_RD_CUR;
        end
      end
      mabr_pkg::ST_RD_CUR: state_nxt = mabr_pkg::ST_RD_OLD;
      mabr_pkg::ST_RD_OLD: state_nxt = mabr_pkg::ST_DIV;
      mabr_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = mabr_pkg::ST_EMIT;
        end
      end
      mabr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = (fin_r && !is_last_out) ? mabr_pkg::ST_RD_CUR : mabr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mabr_pkg::ST_IDLE;
    endcase
  end

  // -------------------------------------------------------- state outputs
  always_comb begin
    in_if.ready = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = out_ptr_r;
    div_start   = 1'b0;
    case (state_r)
      mabr_pkg::ST_IDLE: in_if.ready = 1'b1;
      mabr_pkg::ST_RD_CUR: mem_re = 1'b1;
      mabr_pkg::ST_RD_OLD: begin
        mem_re    = 1'b1;
        mem_raddr = old_addr;
        div_start = 1'b1;
      end
      mabr_pkg::ST_DIV, mabr_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mabr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------ sample memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wr_ptr_r] <= in_if.sample;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // ----------------------------------------------------- trace bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= '0;
      rcv_r       <= '0;
      newest_r    <= '0;
      out_idx_r   <= '0;
      wr_ptr_r    <= '0;
      out_ptr_r   <= '0;
      sum_r       <= '0;
      fin_r       <= 1'b0;
      emit_pend_r <= 1'b0;
    end else if (in_fire) begin
      // Take the sample into the running window sum
      half_r      <= half_use;
      newest_r    <= rcv_r;
      fin_r       <= in_fin;
      emit_pend_r <= need_emit;
      sum_r       <= sum_r + SUM_W'(in_if.sample);
      if (in_fin) begin
        rcv_r    <= '0;
        wr_ptr_r <= '0;
      end else begin
        rcv_r    <= rcv_r + 1'b1;
        wr_ptr_r <= wr_ptr_inc;
      end
    end else if (emit_fire) begin
      // Advance to the next output (dropping the oldest past half) or end trace
      emit_pend_r <= !is_last_out && fin_r;
      if (is_last_out) begin
        sum_r     <= '0;
        out_idx_r <= '0;
        out_ptr_r <= '0;
      end else begin
        if (past_half) begin
          sum_r <= sum_r - SUM_W'(rdata_r);
        end
        out_idx_r <= out_idx_r + 1'b1;
        out_ptr_r <= out_ptr_inc;
      end
    end
  end

  // Operands for the mean
  always_ff @(posedge clk) begin
    if (state_r == mabr_pkg::ST_RD_CUR) begin
      count_r <= CNT_W'(count_w);
    end
    if (state_r == mabr_pkg::ST_RD_OLD) begin
      cur_r     <= rdata_r;
      sum_neg_r <= sum_r[SUM_W-1];
    end
  end

  mabr_div #(
    .DIVIDEND_BITS (SUM_W),
    .DIVISOR_BITS  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      residual_r <= residual_w[SAMPLE_BITS:0];
      index_r    <= (32'(out_idx_r) > 32'(mabr_pkg::INDEX_MAX)) ?
                    mabr_pkg::INDEX_MAX : mabr_pkg::INDEX_BITS'(out_idx_r);
      last_r     <= is_last_out;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.residual     = residual_r;
  assign out_if.sample_index = index_r;
  assign out_if.last_result  = last_r;

  // -------------------------------------------------------------- assertions
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mabr_pkg::ST_RD_OLD) |-> (count_r != '0))
    else $error("window count is zero at divide start");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !div_busy)
    else $error("sample accepted while divider runs");

  a_trace_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && is_last_out) |=> (sum_r == '0 && out_idx_r == '0 && rcv_r == '0))
    else $error("trace state not cleared after final result");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mabr_pkg::ST_IDLE) |-> (out_idx_r <= newest_r && emit_pend_r))
    else $error("output index beyond newest sample");

endmodule

`default_nettype wire

>>> rtl/mabr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Unsigned operands; no package dependencies.
`default_nettype none

module mabr_div #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic                          busy,
  output logic [DIVIDEND_BITS-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo_r;
  logic [DIVISOR_BITS-1:0]  rem_r;
  logic [DIVISOR_BITS-1:0]  div_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     busy_r;

  logic [DIVISOR_BITS:0]    trial;
  logic                     fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, div_r};

  // Control: count the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVIDEND_BITS);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CNT_W'(1);
    end
  end

  // Datapath: remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_BITS-2:0], fits};
      rem_r <= fits ? DIVISOR_BITS'(trial - {1'b0, div_r}) : trial[DIVISOR_BITS-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> bench/moving_average_background_removal_core_tb.sv
// Self-checking bench for moving_average_background_removal_core: streams radar
// traces through the valid/ready channels and checks every residual in order.
// Depends on mabr_pkg, mabr_in_if / mabr_out_if and the core itself.
module moving_average_background_removal_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = mabr_pkg::WINDOW_DEPTH_DEF;
  localparam int TRACE_MAX     = mabr_pkg::MAX_TRACE_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 270;
  localparam logic [mabr_pkg::CFG_ADDR_BITS-1:0] WINDOW_SIZE_ADDR =
    mabr_pkg::CFG_ADDR_BITS'(4 * int'(mabr_pkg::REG_IDX_WINDOW_SIZE));

  typedef struct packed {
    logic signed [16:0] residual;
    logic [11:0]        index;
    logic               last;
  } residual_t;

  typedef enum logic [1:0] {
    ROW_WINDOW,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic signed [15:0] sample;
    logic               last;
    logic [6:0]         window;
    logic               typed;
    residual_t          want;
  } stim_row_t;

  localparam residual_t NO_WANT = '0;
  localparam int DIRECTED_ROWS = 30;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [mabr_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [mabr_pkg::CFG_DATA_BITS-1:0] pwdata, prdata;
  logic pready;

  mabr_in_if  in_if ();
  mabr_out_if out_if ();

  moving_average_background_removal_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Directed traces: reset window, extremes, zero window, short and split traces
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 7'd0,   1'b1, '{17'sd0, 12'd0, 1'b1}},
    '{ROW_SAMPLE, 16'sh8000, 1'b1, 7'd0,   1'b1, '{17'sd0, 12'd0, 1'b1}},
    '{ROW_WINDOW, 16'sd0,    1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 7'd0,   1'b1, '{17'sd0, 12'd0, 1'b0}},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 7'd0,   1'b1, '{17'sd0, 12'd1, 1'b0}},
    '{ROW_SAMPLE, 16'sh5555, 1'b1, 7'd0,   1'b1, '{17'sd0, 12'd2, 1'b1}},
    '{ROW_WINDOW, 16'sd0,    1'b0, 7'd2,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh8000, 1'b1, 7'd0,   1'b0, NO_WANT},
    '{ROW_WINDOW, 16'sd0,    1'b0, 7'd127, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'shFFFF, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh0001, 1'b1, 7'd0,   1'b0, NO_WANT},
    '{ROW_WINDOW, 16'sd0,    1'b0, 7'd5,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd100,  1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, -16'sd200, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd300,  1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_WINDOW, 16'sd0,    1'b0, 7'd126, 1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh8000, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd7,    1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, -16'sd9,   1'b1, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd1,    1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd2,    1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sd3,    1'b0, 7'd0,   1'b0, NO_WANT},
    '{ROW_SAMPLE, 16'sh2AAA, 1'b1, 7'd0,   1'b0, NO_WANT}
  };

  // Predictor state: register copy, trace history and window bookkeeping
  logic [6:0]  cfg_window = mabr_pkg::WINDOW_SIZE_RESET;
  longint      trace_store [DEPTH];
  longint      running_sum = 0;
  int unsigned taken_count = 0;
  int unsigned emit_index  = 0;
  int unsigned half_width  = 0;

  residual_t pending_residuals [$];

  int  error_count       = 0;
  int  samples_sent      = 0;
  int  residuals_checked = 0;
  int  window_writes     = 0;
  bit  steady_flow       = 1'b0;

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (after %0d residuals)",
             what, got, want, residuals_checked);
    error_count++;
  endtask

  function automatic int draw_gap();
    return steady_flow ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic int unsigned half_of(input logic [6:0] ws);
    int unsigned h;
    int unsigned cap;
    h   = (int'(ws) | 1) / 2;
    cap = (DEPTH - 1) / 2;
    return (h > cap) ? cap : h;
  endfunction

  // Emit the residual at emit_index against samples up to newest, then slide
  function automatic void queue_residual(input int unsigned newest, input bit tail);
    int unsigned lo;
    longint      span;
    longint      mean;
    longint      diff;
    residual_t   item;
    lo   = (emit_index >= half_width) ? emit_index - half_width : 0;
    span = longint'(newest) - longint'(lo) + 1;
    mean = running_sum / span;
    diff = trace_store[emit_index % DEPTH] - mean;
    item.residual = diff[16:0];
    item.index    = (emit_index > int'(mabr_pkg::INDEX_MAX)) ? mabr_pkg::INDEX_MAX
                                                             : emit_index[11:0];
    item.last     = tail;
    pending_residuals.push_back(item);
    if (emit_index >= half_width)
      running_sum -= trace_store[(emit_index - half_width) % DEPTH];
    emit_index++;
  endfunction

  function automatic void predict_residuals(input logic signed [15:0] s, input logic flag);
    int unsigned r;
    bit          fin;
    r   = taken_count;
    fin = flag;
    if (r == 0) half_width = half_of(cfg_window);
    trace_store[r % DEPTH] = longint'(s);
    running_sum += longint'(s);
    if (r >= TRACE_MAX - 1) fin = 1'b1;
    if (!fin) begin
      if (r >= half_width) queue_residual(r, 1'b0);
      taken_count = r + 1;
    end else begin
      while (emit_index <= r) queue_residual(r, emit_index == r);
      running_sum = 0;
      taken_count = 0;
      emit_index  = 0;
    end
  endfunction

  // Present one sample after a random gap; hold valid until the transaction
  task automatic push_sample(input logic signed [15:0] s, input logic flag);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= flag;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_residuals(s, flag);
    samples_sent++;
  endtask

  // Drop valid, wait for all outstanding residuals, then let the core go idle
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (pending_residuals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [6:0] ws, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WINDOW_SIZE_ADDR;
    pwdata  <= {25'd0, ws};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_window(input logic [6:0] ws);
    logic [31:0] rd;
    settle_block();
    apb_access(1'b1, ws, rd);
    cfg_window = ws;
    window_writes++;
    @(posedge clk);
    apb_access(1'b0, 7'd0, rd);
    if (rd !== {25'd0, ws}) note_mismatch("window_size readback", rd, ws);
  endtask

  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($signed(int'($urandom_range(0, 200)) - 100));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd127;
      3:       return 7'd126;
      default: return 7'($urandom_range(1, 40));
    endcase
  endfunction

  // Result side: random stalls, compare every transaction with the oldest prediction
  initial begin
    residual_t want;
    int        stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      if (pending_residuals.size() == 0) begin
        note_mismatch("unexpected residual at index", out_if.sample_index, -1);
      end else begin
        want = pending_residuals.pop_front();
        if (out_if.residual !== want.residual)
          note_mismatch("residual", out_if.residual, want.residual);
        if (out_if.sample_index !== want.index)
          note_mismatch("sample_index", out_if.sample_index, want.index);
        if (out_if.last_result !== want.last)
          note_mismatch("last_result", out_if.last_result, want.last);
      end
      residuals_checked++;
    end
  end

  // Hard stop in case the core hangs
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus: reset, directed table, then random traces
  initial begin
    stim_row_t   row;
    logic [31:0] rd;
    int          random_items;
    int          trace_len;
    int          split;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.last_sample <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register must come out of reset at its default
    apb_access(1'b0, 7'd0, rd);
    if (rd !== {25'd0, mabr_pkg::WINDOW_SIZE_RESET})
      note_mismatch("window_size after reset", rd, mabr_pkg::WINDOW_SIZE_RESET);

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_WINDOW) begin
        write_window(row.window);
      end else begin
        push_sample(row.sample, row.last);
        if (row.typed) begin
          void'(pending_residuals.pop_back());
          pending_residuals.push_back(row.want);
        end
      end
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_window(pick_window());
      steady_flow = ($urandom_range(0, 3) == 0);
      trace_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
      split = (trace_len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, trace_len - 1)
                                                          : 0;
      for (int i = 0; i < trace_len; i++) begin
        if (split != 0 && i == split) write_window(pick_window());
        else if ($urandom_range(0, 49) == 0) settle_block();
        push_sample(draw_sample(), i == trace_len - 1);
        random_items++;
      end
    end
    steady_flow = 1'b0;

    settle_block();
    $display("Streamed %0d samples under %0d window settings, %0d residuals checked.",
             samples_sent, window_writes, residuals_checked);
    $display("Covered zero, odd, even and capped windows, short and split traces.");
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
